// ===== rtl/java_lcg_random_unit_macros.svh =====
// Assertion macros for the checker file of the random unit.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef JAVA_LCG_RANDOM_UNIT_MACROS_SVH
`define JAVA_LCG_RANDOM_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JLCG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define JLCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jlcg_pkg.sv =====
// Package of the 48-bit LCG random unit: constants, operation codes and the
// classified operation record passed from front end to back end. No dependencies.
`default_nettype none

package jlcg_pkg;

	localparam int unsigned LCG_W    = 48;
	localparam int unsigned DRAW31_W = 31;

	localparam logic [34:0] LCG_MULT  = 35'h5DEECE66D;
	localparam logic [47:0] LCG_INC   = 48'hB;
	localparam logic [47:0] LCG_RESET = 48'h5DEECE66D;

	localparam int unsigned FIFO_DEPTH_DEF = 2;

	// Input action codes.
	typedef enum logic [2:0] {
		ACT_SEED   = 3'd0,
		ACT_BITS   = 3'd1,
		ACT_INT    = 3'd2,
		ACT_LONG   = 3'd3,
		ACT_DOUBLE = 3'd4
	} action_t;

	// Operation kinds after classification by the front end.
	typedef enum logic [2:0] {
		KIND_NOP      = 3'd0,
		KIND_SEED     = 3'd1,
		KIND_BITS     = 3'd2,
		KIND_BAD      = 3'd3,
		KIND_INT_POW2 = 3'd4,
		KIND_INT_DIV  = 3'd5,
		KIND_LONG     = 3'd6,
		KIND_DOUBLE   = 3'd7
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [47:0] seed_state;  // scrambled seed, ready to load
		logic [5:0]  k;           // draw width, saturated to 32
		logic [30:0] bound;       // positive bound for next int
		logic [4:0]  pow_sh;      // right shift of a 31-bit draw for power-of-two bounds
	} jlcg_op_t;

endpackage

`default_nettype wire

// ===== rtl/jlcg_front.sv =====
// Front end of the LCG random unit: takes input beats and classifies them.
// Depends on jlcg_pkg; feeds jlcg_fifo.
`default_nettype none

module jlcg_front import jlcg_pkg::*; (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [2:0]  action,
	input  wire logic signed [63:0] seed_value,
	input  wire logic        [5:0]  bit_count,
	input  wire logic signed [31:0] upper_bound,
	input  wire logic               q_full,
	output logic                    push,
	output jlcg_op_t                push_op
);

	logic       bound_pos;
	logic       bound_pow2;
	logic [4:0] bound_lg;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	assign bound_pos  = !upper_bound[31] && (upper_bound != 32'sd0);
	assign bound_pow2 = (upper_bound[30:0] & (~upper_bound[30:0] + 31'd1)) == upper_bound[30:0];

	// Position of the highest set bit, used only when the bound is a power of two.
	always_comb begin
		bound_lg = '0;
		for (int i = 0; i < 31; i++) begin
			if (upper_bound[i])
				bound_lg = 5'(i);
		end
	end

	always_comb begin
		push_op.seed_state = seed_value[47:0] ^ {13'd0, LCG_MULT};
		push_op.k          = (bit_count > 6'd32) ? 6'd32 : bit_count;
		push_op.bound      = upper_bound[30:0];
		push_op.pow_sh     = 5'd31 - bound_lg;
		unique case (action)
			ACT_SEED:   push_op.kind = KIND_SEED;
			ACT_BITS:   push_op.kind = KIND_BITS;
			ACT_INT: begin
				if (!bound_pos)
					push_op.kind = KIND_BAD;
				else if (bound_pow2)
					push_op.kind = KIND_INT_POW2;
				else
					push_op.kind = KIND_INT_DIV;
			end
			ACT_LONG:   push_op.kind = KIND_LONG;
			ACT_DOUBLE: push_op.kind = KIND_DOUBLE;
			default:    push_op.kind = KIND_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/jlcg_fifo.sv =====
// Short queue of classified operations between front end and back end.
// Depends on jlcg_pkg for the operation record.
`default_nettype none

module jlcg_fifo import jlcg_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  jlcg_op_t      push_op,
	output logic          full,
	input  wire logic     pop,
	output jlcg_op_t      pop_op,
	output logic          nonempty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	jlcg_op_t            mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_op   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/jlcg_back.sv =====
// Back end of the LCG random unit: LCG step on a shared multiplier, a
// bit-serial remainder unit for bounded draws, and the output register.
// Depends on jlcg_pkg; takes operations from jlcg_fifo.
`default_nettype none

module jlcg_back import jlcg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               op_valid,
	input  jlcg_op_t                op,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [63:0]      value,
	output logic                    bad_bound
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL_LO = 6'b000010,
		ST_MUL_HI = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_CHECK  = 6'b010000,
		ST_DONE   = 6'b100000
	} back_st_t;

	localparam logic [4:0] DIV_LAST = 5'(DRAW31_W - 1);

	back_st_t          st_q;
	jlcg_op_t          cur_q;
	logic [47:0]       lcg_q;
	logic [47:0]       prod_q;
	logic              idx_q;
	logic [31:0]       hold_q;
	logic [30:0]       r_q;
	logic [30:0]       rem_q;
	logic [30:0]       quo_q;
	logic [4:0]        cnt_q;
	logic [63:0]       res_value_q;
	logic              res_bad_q;
	logic              out_valid_q;
	logic [63:0]       value_q;
	logic              bad_q;

	logic [23:0]       mul_a;
	logic [34:0]       mul_b;
	logic [58:0]       prod;
	logic [47:0]       next_lcg;
	logic [31:0]       top32;
	logic [30:0]       r31;
	logic [31:0]       bits_val;
	logic [31:0]       trial;
	logic              fits;
	logic [31:0]       check_t;
	logic              out_free;

	// The state splits into two 24-bit halves; the high half only needs the low
	// 24 bits of the multiplier because everything above bit 47 is dropped.
	assign mul_a    = (st_q == ST_MUL_HI) ? lcg_q[47:24] : lcg_q[23:0];
	assign mul_b    = (st_q == ST_MUL_HI) ? {11'd0, LCG_MULT[23:0]} : LCG_MULT;
	assign prod     = {35'd0, mul_a} * {24'd0, mul_b};
	assign next_lcg = prod_q + {prod[23:0], 24'd0};

	assign top32    = next_lcg[47:16];
	assign r31      = next_lcg[47:17];
	assign bits_val = top32 >> (6'd32 - cur_q.k);

	assign trial    = {rem_q, quo_q[30]};
	assign fits     = trial >= {1'b0, cur_q.bound};
	assign check_t  = {1'b0, r_q} - {1'b0, rem_q} + {1'b0, cur_q.bound} - 32'd1;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (st_q == ST_IDLE) && op_valid;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign bad_bound = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cur_q       <= '0;
			lcg_q       <= LCG_RESET;
			prod_q      <= '0;
			idx_q       <= 1'b0;
			hold_q      <= '0;
			r_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			res_value_q <= '0;
			res_bad_q   <= 1'b0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			bad_q       <= 1'b0;
		end else begin
			// The result register fills from the done state and empties on a taken beat.
			if ((st_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (st_q)
				ST_IDLE: begin
					if (op_valid) begin
						cur_q       <= op;
						idx_q       <= 1'b0;
						res_value_q <= '0;
						res_bad_q   <= 1'b0;
						priority case (op.kind)
							KIND_SEED: begin
								lcg_q <= op.seed_state;
								st_q  <= ST_DONE;
							end
							KIND_BAD: begin
								res_bad_q <= 1'b1;
								st_q      <= ST_DONE;
							end
							KIND_NOP:
								st_q <= ST_DONE;
							default:
								st_q <= ST_MUL_LO;
						endcase
					end
				end
				ST_MUL_LO: begin
					prod_q <= prod[47:0] + LCG_INC;
					st_q   <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					lcg_q <= next_lcg;
					unique case (cur_q.kind)
						KIND_BITS: begin
							res_value_q <= {32'd0, bits_val};
							st_q        <= ST_DONE;
						end
						KIND_INT_POW2: begin
							res_value_q <= {33'd0, r31 >> cur_q.pow_sh};
							st_q        <= ST_DONE;
						end
						KIND_INT_DIV: begin
							r_q   <= r31;
							quo_q <= r31;
							rem_q <= '0;
							cnt_q <= '0;
							st_q  <= ST_DIV;
						end
						KIND_LONG: begin
							if (!idx_q) begin
								hold_q <= top32;
								idx_q  <= 1'b1;
								st_q   <= ST_MUL_LO;
							end else begin
								res_value_q <= {hold_q, 32'd0} + {{32{top32[31]}}, top32};
								st_q        <= ST_DONE;
							end
						end
						KIND_DOUBLE: begin
							if (!idx_q) begin
								hold_q <= {6'd0, next_lcg[47:22]};
								idx_q  <= 1'b1;
								st_q   <= ST_MUL_LO;
							end else begin
								res_value_q <= {11'd0, hold_q[25:0], next_lcg[47:21]};
								st_q        <= ST_DONE;
							end
						end
						default:
							st_q <= ST_DONE;
					endcase
				end
				ST_DIV: begin
					// Restoring division, one dividend bit per cycle.
					rem_q <= fits ? 31'(trial - {1'b0, cur_q.bound}) : trial[30:0];
					quo_q <= {quo_q[29:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST)
						st_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// A draw from the top partial interval is rejected and redrawn.
					if (check_t[31]) begin
						st_q <= ST_MUL_LO;
					end else begin
						res_value_q <= {33'd0, rem_q};
						st_q        <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						value_q <= res_value_q;
						bad_q   <= res_bad_q;
						st_q    <= ST_IDLE;
					end
				end
				default:
					st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/java_lcg_random_unit.sv =====
// Top level of the 48-bit LCG random unit (Random-compatible draws).
// Depends on jlcg_pkg, jlcg_front, jlcg_fifo and jlcg_back.
//
// This block keeps a 48-bit linear congruential state, stepped as
// state = (state * 0x5DEECE66D + 0xB) mod 2^48, and answers one result beat for
// every input beat: set seed (value 0), next bits (top k bits, k saturated to 32),
// next bounded int (bad_bound set and value 0 for a bound that is not positive),
// next long (two 32-bit draws, low half sign-extended) and next double (the
// 53-bit numerator over 2^53). Unused action codes give a zero result and leave
// the state alone. After reset the state is 0x5DEECE66D, as after seed zero.
// The front end classifies each beat and pushes it into a small queue, so input
// beats are taken whenever the queue has room, even while the back end is busy or
// a result waits in the output register. Each LCG step runs the low-half and
// high-half multiply states on one shared 24 by 35 bit multiplier. Set seed, a
// bad bound or an unused code go from idle straight to done; next bits and a
// power-of-two bound take one draw, next long and next double two. A bound that
// is not a power of two runs a bit-serial remainder over the 31 draw bits after
// each draw, and a rejected draw repeats both. For most bounds the first try is
// accepted, but for bounds just above 2^30 about half of all draws are rejected.
`default_nettype none

module java_lcg_random_unit import jlcg_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic        [2:0]  action,
	input  wire logic signed [63:0] seed_value,
	input  wire logic        [5:0]  bit_count,
	input  wire logic signed [31:0] upper_bound,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [63:0]      value,
	output logic                    bad_bound
);

	logic     push;
	jlcg_op_t push_op;
	logic     q_full;
	logic     pop;
	jlcg_op_t pop_op;
	logic     q_nonempty;

	// Front end: handshake on the input side and operation classification.
	jlcg_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.seed_value  (seed_value),
		.bit_count   (bit_count),
		.upper_bound (upper_bound),
		.q_full      (q_full),
		.push        (push),
		.push_op     (push_op)
	);

	// Queue that lets the front end keep taking beats while the back end works.
	jlcg_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.full     (q_full),
		.pop      (pop),
		.pop_op   (pop_op),
		.nonempty (q_nonempty)
	);

	// Back end: generator state, draw sequencing and the result register.
	jlcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_nonempty),
		.op        (pop_op),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.bad_bound (bad_bound)
	);

endmodule

`default_nettype wire

// ===== rtl/jlcg_checker.sv =====
// Port-level checker for the LCG random unit, bound to the top level.
// Depends on java_lcg_random_unit_macros.svh and the top-level port names.
`default_nettype none

`include "java_lcg_random_unit_macros.svh"

module jlcg_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [63:0] value,
	input  wire logic               bad_bound
);

	// Beats taken in minus beats delivered.
	logic [7:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			if ((in_valid && in_ready) && !(out_valid && out_ready))
				pend_q <= pend_q + 1'b1;
			else if (!(in_valid && in_ready) && (out_valid && out_ready))
				pend_q <= pend_q - 1'b1;
		end
	end

	`JLCG_ASSERT_NOW(a_no_extra_result, out_valid, pend_q != 8'd0, "result beat without an input beat")
	`JLCG_ASSERT_NOW(a_bad_is_zero, out_valid && bad_bound, value == 64'sd0, "bad bound with nonzero value")
	`JLCG_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
	`JLCG_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(value) && $stable(bad_bound), "result changed while stalled")

endmodule

bind java_lcg_random_unit jlcg_checker u_chk (.*);

`default_nettype wire
